/* sv/iff_pkg.sv */
// ----------------------------------------------------------------------------
// iff_pkg
// shared types and constants for the integer field formatter
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int DIGIT_BUFFER_DEF = 22;
    localparam int MAX_FIELD_DEF    = 60;
    localparam int FIELD_CAP        = 64;

    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;

    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_ALT   = 3;
    localparam int FLAG_ZERO  = 4;
    localparam int FLAG_GROUP = 5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        is_unsigned;
        logic [1:0]  base_select;
        logic [5:0]  field_width;
        logic [6:0]  precision;
        logic [5:0]  format_flags;
        logic        upper_case;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_LSPACE,
        E_SIGN,
        E_PREFIX,
        E_ZEROS,
        E_DIGITS,
        E_TSPACE
    } t_emit_state;

    // ascii for one digit value
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10) begin
                c = CH_ZERO + {4'd0, d};
            end else if (upper) begin
                c = 8'h37 + {4'd0, d};
            end else begin
                c = 8'h57 + {4'd0, d};
            end
            return c;
        end
    endfunction

endpackage

/* sv/iff_front.sv */
// ----------------------------------------------------------------------------
// iff_front
// accepts an item, converts the magnitude to digits one per cycle and works
// out the padding counts, then pushes a job into the queue
// ----------------------------------------------------------------------------
module iff_front
    import iff_pkg::*;
#(
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF,
    parameter int MAX_FIELD    = MAX_FIELD_DEF,
    parameter int DW           = $clog2(DIGIT_BUFFER + 1),
    parameter int JOB_W        = 8 + 8 + 3 + 7 + DW + 1 + 1 + 1 + 4 * DIGIT_BUFFER
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_item         i_item,
    output logic             o_busy,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_full
);

    t_front_state r_state, n_state;
    t_in_item     r_item;
    logic [63:0]  r_val;
    logic [DIGIT_BUFFER-1:0][3:0] r_dig;
    logic [DW-1:0] r_pos;
    logic          r_neg;
    logic          r_nz;

    logic [3:0]  w_rem;
    logic [63:0] w_quo;
    logic [63:0] w_q10;
    logic [67:0] w_tmp;
    logic [63:0] w_mag;
    logic        w_neg;

    // magnitude and sign at entry
    always_comb begin
        w_neg = ~i_item.is_unsigned & i_item.value_bits[63];
        w_mag = w_neg ? (64'd0 - i_item.value_bits) : i_item.value_bits;
    end

    // one digit per cycle; decimal uses shift-add divide by ten
    always_comb begin
        w_q10 = (r_val >> 1) + (r_val >> 2);
        w_q10 = w_q10 + (w_q10 >> 4);
        w_q10 = w_q10 + (w_q10 >> 8);
        w_q10 = w_q10 + (w_q10 >> 16);
        w_q10 = w_q10 + (w_q10 >> 32);
        w_q10 = w_q10 >> 3;
        w_tmp = {4'd0, r_val} - {w_q10, 3'd0} - {3'd0, w_q10, 1'b0};
        if (w_tmp > 68'd9) begin
            w_q10 = w_q10 + 64'd1;
            w_tmp = w_tmp - 68'd10;
        end
        priority case (1'b1)
            r_item.base_select == BASE_OCT: begin
                w_quo = r_val >> 3;
                w_rem = {1'b0, r_val[2:0]};
            end
            r_item.base_select == BASE_DEC: begin
                w_quo = w_q10;
                w_rem = w_tmp[3:0];
            end
            default: begin
                w_quo = r_val >> 4;
                w_rem = r_val[3:0];
            end
        endcase
    end

    // job fields
    logic [6:0]  w_prec;
    logic        w_noprec;
    logic [5:0]  w_width;
    logic [6:0]  w_seps;
    logic [13:0] w_s43;
    logic [6:0]  w_big;
    logic [7:0]  w_zpad, w_spad;
    logic [8:0]  w_zt, w_st;
    logic [7:0]  w_sign;
    logic        w_prefix;
    logic [6:0]  w_posx;

    always_comb begin
        w_posx   = 7'(r_pos);
        w_width  = (r_item.field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD)
                                                        : r_item.field_width;
        w_noprec = r_item.precision[6];
        w_prec   = w_noprec ? 7'd0
                 : ((r_item.precision > 7'(MAX_FIELD)) ? 7'(MAX_FIELD)
                                                       : r_item.precision);
        w_prefix = 1'b0;
        if (r_item.format_flags[FLAG_ALT] && r_nz) begin
            if (r_item.base_select == BASE_OCT) begin
                if (w_prec <= w_posx) begin
                    w_prec = w_posx + 7'd1;
                end
            end else if (r_item.base_select != BASE_DEC) begin
                w_prefix = 1'b1;
            end
        end
        if (r_neg) begin
            w_sign = CH_MINUS;
        end else if (!r_item.is_unsigned && r_item.format_flags[FLAG_PLUS]) begin
            w_sign = CH_PLUS;
        end else if (!r_item.is_unsigned && r_item.format_flags[FLAG_SPACE]) begin
            w_sign = CH_SPACE;
        end else begin
            w_sign = 8'd0;
        end
        // comma count: (digits - 1) / 3 by reciprocal multiply
        w_s43  = 14'(w_posx - 7'd1) * 14'd43;
        w_seps = 7'd0;
        if (r_item.format_flags[FLAG_GROUP]) begin
            w_seps = {1'b0, w_s43[12:7]};
        end
        w_big = (w_prec > w_posx) ? w_prec : w_posx;
        w_zt  = {2'd0, w_prec} - {2'd0, w_posx} - {2'd0, w_seps};
        w_st  = {3'd0, w_width} - {2'd0, w_seps} - {2'd0, w_big}
              - ((w_sign != 8'd0) ? 9'd1 : 9'd0) - (w_prefix ? 9'd2 : 9'd0);
        w_zpad = w_zt[8] ? 8'd0 : w_zt[7:0];
        w_spad = w_st[8] ? 8'd0 : w_st[7:0];
        if (!r_item.format_flags[FLAG_LEFT] && r_item.format_flags[FLAG_ZERO]
            && w_noprec) begin
            w_zpad = w_zpad + w_spad;
            w_spad = 8'd0;
        end
    end

    // sign travels as three bits that keep minus, plus and space apart
    assign o_job = {w_spad, w_zpad, w_sign[5], w_sign[1:0], w_seps, r_pos,
                    r_item.format_flags[FLAG_LEFT], w_prefix, r_item.upper_case,
                    r_dig};

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_quo == 64'd0 || r_pos == DW'(DIGIT_BUFFER - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_item <= i_item;
            r_val  <= w_mag;
            r_neg  <= w_neg;
            r_nz   <= (w_mag != 64'd0);
            r_pos  <= '0;
        end else if (r_state == S_CONV) begin
            r_dig[r_pos] <= w_rem;
            r_val        <= w_quo;
            r_pos        <= r_pos + DW'(1);
        end
    end

endmodule

/* sv/iff_queue.sv */
// ----------------------------------------------------------------------------
// iff_queue
// two-entry job queue between the converter and the emitter
// ----------------------------------------------------------------------------
module iff_queue
    import iff_pkg::*;
#(
    parameter int JOB_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [JOB_W-1:0] o_job
);

    logic [1:0][JOB_W-1:0] r_mem;
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* sv/iff_emit.sv */
// ----------------------------------------------------------------------------
// iff_emit
// walks the parts of one field and, once its first character is out, sends one character per cycle
// ----------------------------------------------------------------------------
module iff_emit
    import iff_pkg::*;
#(
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF,
    parameter int DW           = $clog2(DIGIT_BUFFER + 1),
    parameter int JOB_W        = 8 + 8 + 3 + 7 + DW + 1 + 1 + 1 + 4 * DIGIT_BUFFER
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_pop,
    output logic             o_strobe,
    output t_out_item        o_item
);

    logic [7:0] r_spad, r_zpad;
    logic [2:0] r_sgn;
    logic [6:0] r_seps;
    logic [DW-1:0] r_pos;
    logic       r_left, r_prefix, r_upper, r_pfx2, r_comma;
    logic [DIGIT_BUFFER-1:0][3:0] r_dig;
    logic [5:0] r_ocnt;

    t_emit_state r_st, n_st;
    logic        r_strobe;
    t_out_item   r_out;

    logic [7:0]  n_ch;
    logic        w_emit, w_done;
    logic [7:0]  w_sign;

    assign w_sign = (r_sgn == {CH_MINUS[5], CH_MINUS[1:0]}) ? CH_MINUS
                  : (r_sgn == {CH_PLUS[5], CH_PLUS[1:0]})   ? CH_PLUS : CH_SPACE;

    // next state from what remains of the field
    function automatic t_emit_state after_sign(input logic pre, input logic [7:0] z);
        begin
            if (pre) return E_PREFIX;
            if (z != 8'd0) return E_ZEROS;
            return E_DIGITS;
        end
    endfunction

    logic w_last_digit;
    logic [DW-1:0] w_pm1;
    logic [13:0] w_m43;
    logic w_comma_next;

    always_comb begin
        w_pm1        = r_pos - DW'(1);
        w_last_digit = (r_pos == DW'(1)) && !r_comma;
        // multiple of three left: compare against three times (x * 43) >> 7
        w_m43        = 14'(w_pm1) * 14'd43;
        w_comma_next = (r_seps != 7'd0) && (w_pm1 != '0)
                     && (7'(w_pm1) == 7'(w_m43[12:7]) * 7'd3);
        n_st   = r_st;
        n_ch   = CH_SPACE;
        w_emit = 1'b0;
        w_done = 1'b0;
        o_pop  = 1'b0;
        unique case (r_st)
            E_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_st  = E_LSPACE;
                end
            end
            E_LSPACE: begin
                if (!r_left && r_spad != 8'd0) begin
                    w_emit = 1'b1;
                    n_ch   = CH_SPACE;
                    if (r_spad == 8'd1) begin
                        n_st = (r_sgn != 3'd0) ? E_SIGN : after_sign(r_prefix, r_zpad);
                    end
                end else begin
                    n_st = (r_sgn != 3'd0) ? E_SIGN : after_sign(r_prefix, r_zpad);
                end
            end
            E_SIGN: begin
                w_emit = 1'b1;
                n_ch   = w_sign;
                n_st   = after_sign(r_prefix, r_zpad);
            end
            E_PREFIX: begin
                w_emit = 1'b1;
                if (!r_pfx2) begin
                    n_ch = CH_ZERO;
                end else begin
                    n_ch = r_upper ? 8'h58 : 8'h78;
                    n_st = (r_zpad != 8'd0) ? E_ZEROS : E_DIGITS;
                end
            end
            E_ZEROS: begin
                w_emit = 1'b1;
                n_ch   = CH_ZERO;
                if (r_zpad == 8'd1) begin
                    n_st = E_DIGITS;
                end
            end
            E_DIGITS: begin
                w_emit = 1'b1;
                if (r_comma) begin
                    n_ch = CH_COMMA;
                end else begin
                    n_ch = digit_char(r_dig[w_pm1], r_upper);
                end
                if (w_last_digit) begin
                    if (r_left && r_spad != 8'd0) begin
                        n_st = E_TSPACE;
                    end else begin
                        w_done = 1'b1;
                        n_st   = E_IDLE;
                    end
                end
            end
            E_TSPACE: begin
                w_emit = 1'b1;
                n_ch   = CH_SPACE;
                if (r_spad == 8'd1) begin
                    w_done = 1'b1;
                    n_st   = E_IDLE;
                end
            end
            default: n_st = E_IDLE;
        endcase
        // field cap: 64th character always ends it
        if (w_emit && r_ocnt == 6'd63) begin
            w_done = 1'b1;
            n_st   = E_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= E_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_strobe <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_char  <= n_ch;
        r_out.last_char <= w_done;
        if (o_pop) begin
            {r_spad, r_zpad, r_sgn, r_seps, r_pos, r_left, r_prefix,
             r_upper, r_dig} <= i_job;
            r_pfx2  <= 1'b0;
            r_comma <= 1'b0;
            r_ocnt  <= 6'd0;
        end else if (w_emit) begin
            r_ocnt <= r_ocnt + 6'd1;
            unique case (r_st)
                E_LSPACE, E_TSPACE: r_spad <= r_spad - 8'd1;
                E_PREFIX:           r_pfx2 <= 1'b1;
                E_ZEROS:            r_zpad <= r_zpad - 8'd1;
                E_DIGITS: begin
                    if (r_comma) begin
                        r_comma <= 1'b0;
                    end else begin
                        r_pos   <= w_pm1;
                        r_comma <= w_comma_next;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_out;

endmodule

/* sv/integer_field_formatter_core.sv */
// ----------------------------------------------------------------------------
// integer_field_formatter_core
// printf-style integer to ascii field formatter
// ----------------------------------------------------------------------------
// Usage: drive i_item and raise start while busy is low; the item is taken
// on that edge. The formatted field comes out on o_item, one character per
// beat, each beat marked by o_strobe for exactly one cycle; last_char is set
// on the final beat. The receiver cannot stall the output.
// Flow: the converter works out the digits in its conversion state, then
// pushes the job into the queue; a full queue holds the converter in its
// push state. The emitter pops the job once it is idle; for a field with no
// leading spaces it passes through its leading-space state without a beat.
// The field then streams at one character per cycle (1 to 64 characters).
// Overlap: busy is high while the converter converts and pushes, so the
// next item can be taken once the job is in the queue, while the emitter
// may still send the last field. On long fields the emitter sets the
// sustained rate, with its idle state (and an empty leading-space state).
// Reset: synchronous, active low; clears the controllers and the queue.
// ----------------------------------------------------------------------------
module integer_field_formatter_core
    import iff_pkg::*;
#(
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF,
    parameter int MAX_FIELD    = MAX_FIELD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_item
);

    localparam int DW    = $clog2(DIGIT_BUFFER + 1);
    localparam int JOB_W = 8 + 8 + 3 + 7 + DW + 1 + 1 + 1 + 4 * DIGIT_BUFFER;

    logic             w_push, w_full, w_pop, w_valid;
    logic [JOB_W-1:0] w_job_in, w_job_out;

    iff_front #(.DIGIT_BUFFER(DIGIT_BUFFER), .MAX_FIELD(MAX_FIELD), .DW(DW),
                .JOB_W(JOB_W)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_item,
        .o_busy(busy), .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    iff_queue #(.JOB_W(JOB_W)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_valid), .o_job(w_job_out)
    );

    iff_emit #(.DIGIT_BUFFER(DIGIT_BUFFER), .DW(DW), .JOB_W(JOB_W)) u_emit (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_job(w_job_out), .o_pop(w_pop),
        .o_strobe, .o_item
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && !w_valid)) else $error("pop from empty queue");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

endmodule
